[rtl/core/arav_pkg.sv]
// shared types, constants and helpers for the round-robin converter averager
// no dependencies
package arav_pkg;

  localparam int SLOTS       = 8;
  localparam int AVG_SAMPLES = 4;
  localparam int DEPTH       = SLOTS * AVG_SAMPLES;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BKT_W       = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int CNT_W       = $clog2(AVG_SAMPLES + 1);

  localparam int SAMPLE_W     = 10;
  localparam int SLOT_FIELD_W = 3;
  localparam int VALUE_W      = 16;
  localparam int FACTOR_W     = 16;
  localparam int PROD_W       = VALUE_W + FACTOR_W;
  localparam int SCALE_SHIFT  = 12;
  localparam int CNT_REG_W    = 4;
  localparam int SEL_W        = 24;
  localparam int SEL_FIELD_W  = 3;
  localparam int NUM_FACTORS  = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd4096;

  // transaction kinds
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR3    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR4    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR5    = 3'd7;

  typedef struct packed {
    logic [CNT_REG_W-1:0]                  slot_count;
    logic [SEL_W-1:0]                      scale_sel;
    logic [NUM_FACTORS-1:0][FACTOR_W-1:0]  factor;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] next_slot;
    logic [VALUE_W-1:0]      scaled_value;
  } res_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [BKT_W-1:0] b);
    int a;
    a = int'(s) * AVG_SAMPLES + int'(b);
    return ADDR_W'(a);
  endfunction

endpackage

[rtl/core/arav_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module arav_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/arav_core.sv]
// sequencer with shared accumulate adder and scale multiplier, sample ram and valid bits
// depends on arav_pkg and arav_ram
module arav_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              in_mode,
  input  logic [arav_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic [arav_pkg::SLOT_FIELD_W-1:0] in_slot,
  input  arav_pkg::cfg_t                    cfg,
  output logic                              idle,
  output logic                              res_valid,
  input  logic                              res_take,
  output arav_pkg::res_t                    res
);
  import arav_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_MUL, ST_DONE} state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     cur_slot_r, cur_slot_nxt;
  logic [BKT_W-1:0]      bkt_r, bkt_nxt;
  logic [SLOT_W-1:0]     rd_slot_r, rd_slot_nxt;
  logic                  in_range_r, in_range_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic [VALUE_W-1:0]    acc_r, acc_nxt;
  logic [FACTOR_W-1:0]   factor_r, factor_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [DEPTH-1:0]      valid_r, valid_nxt;

  logic [CNT_REG_W-1:0]  eff_cnt;
  logic [SLOT_W:0]       slot_inc;
  logic                  wrap;
  logic [SEL_FIELD_W-1:0] sel;
  logic                  issue;
  logic                  we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [SAMPLE_W-1:0]   rdata;
  logic [VALUE_W-1:0]    addend;

  arav_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    eff_cnt = cfg.slot_count;
    if (cfg.slot_count == '0) begin
      eff_cnt = CNT_REG_W'(1);
    end else if (int'(cfg.slot_count) > SLOTS) begin
      eff_cnt = CNT_REG_W'(SLOTS);
    end
    slot_inc = {1'b0, cur_slot_r} + (SLOT_W + 1)'(1);
    wrap     = (CNT_REG_W + 1)'(slot_inc) >= (CNT_REG_W + 1)'(eff_cnt);

    sel = cfg.scale_sel[in_slot * SEL_FIELD_W +: SEL_FIELD_W];

    we    = (state_r == ST_IDLE) && start && (in_mode == MODE_TICK);
    waddr = store_addr(cur_slot_r, bkt_r);
    issue = (state_r == ST_SUM) && (int'(cnt_r) < AVG_SAMPLES);
    raddr = store_addr(rd_slot_r, cnt_r[BKT_W-1:0]);

    addend = (pend_r && rd_ok_r && in_range_r) ? VALUE_W'(rdata) : '0;

    state_nxt    = state_r;
    cur_slot_nxt = cur_slot_r;
    bkt_nxt      = bkt_r;
    rd_slot_nxt  = rd_slot_r;
    in_range_nxt = in_range_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = 1'b0;
    rd_ok_nxt    = rd_ok_r;
    acc_nxt      = acc_r;
    factor_nxt   = factor_r;
    prod_nxt     = prod_r;
    valid_nxt    = valid_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_TICK) begin
            valid_nxt[waddr] = 1'b1;
            prod_nxt         = '0;
            if (wrap) begin
              cur_slot_nxt = '0;
              bkt_nxt      = (int'(bkt_r) == AVG_SAMPLES - 1) ? '0 : bkt_r + BKT_W'(1);
            end else begin
              cur_slot_nxt = SLOT_W'(slot_inc);
            end
            state_nxt = ST_DONE;
          end else begin
            in_range_nxt = int'(in_slot) < SLOTS;
            rd_slot_nxt  = SLOT_W'(in_slot);
            cnt_nxt      = '0;
            acc_nxt      = '0;
            factor_nxt   = (int'(sel) < NUM_FACTORS) ? cfg.factor[sel] : cfg.factor[0];
            state_nxt    = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        acc_nxt = acc_r + addend;
        if (issue) begin
          pend_nxt  = 1'b1;
          rd_ok_nxt = valid_r[raddr];
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else if (!pend_r || (int'(cnt_r) == AVG_SAMPLES)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(acc_r) * PROD_W'(factor_r);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cur_slot_r <= '0;
      bkt_r      <= '0;
      valid_r    <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_slot_r <= cur_slot_nxt;
      bkt_r      <= bkt_nxt;
      valid_r    <= valid_nxt;
      pend_r     <= pend_nxt;
    end
    rd_slot_r  <= rd_slot_nxt;
    in_range_r <= in_range_nxt;
    cnt_r      <= cnt_nxt;
    rd_ok_r    <= rd_ok_nxt;
    acc_r      <= acc_nxt;
    factor_r   <= factor_nxt;
    prod_r     <= prod_nxt;
  end

  assign idle             = (state_r == ST_IDLE);
  assign res_valid        = (state_r == ST_DONE);
  assign res.next_slot    = SLOT_FIELD_W'(cur_slot_r);
  assign res.scaled_value = prod_r[SCALE_SHIFT +: VALUE_W];

endmodule

[rtl/core/adc_round_robin_averager_unit.sv]
// a tick goes idle to done; a read runs the sum and multiply states first. Done holds until the
//   output register takes the result; input is accepted only in idle, so a read blocks input
//   through the accumulate loop over the ram read port; a result may wait in the output register
// reset: synchronous active-low rst_n clears slot, bucket, sample valid bits and registers
//   to slot_count 1, selectors 0, factors 4096; no clearing pass
// depends on arav_pkg and arav_core
module adc_round_robin_averager_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,  // sample[9:0], slot[12:10], zero pad
  input  logic                            in_tuser,  // mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata, // next_slot[2:0], scaled_value[18:3], pad
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [arav_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arav_pkg::CFG_DATA_W-1:0] cfg_data
);
  import arav_pkg::*;

  cfg_t cfg_r;
  res_t res;
  res_t out_res_r;
  logic out_valid_r;
  logic idle, res_valid, res_take, start;
  logic [CFG_IDX_W-1:0] fidx;

  assign in_tready = idle;
  assign start     = in_tvalid && in_tready;
  assign res_take  = res_valid && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;
  assign fidx      = cfg_index - REG_FACTOR0;

  arav_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_tuser),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .in_slot   (in_tdata[SAMPLE_W +: SLOT_FIELD_W]),
    .cfg       (cfg_r),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_count <= CNT_REG_W'(1);
      cfg_r.scale_sel  <= '0;
      for (int i = 0; i < NUM_FACTORS; i++) begin
        cfg_r.factor[i] <= FACTOR_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        REG_SLOT_COUNT: cfg_r.slot_count <= cfg_data[CNT_REG_W-1:0];
        REG_SCALE_SEL:  cfg_r.scale_sel  <= cfg_data[SEL_W-1:0];
        [REG_FACTOR0:REG_FACTOR5]: cfg_r.factor[fidx] <= cfg_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.scaled_value, out_res_r.next_slot};

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a transaction was in progress");

  a_take_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_tvalid)
    else $error("finished result did not reach the output register");

  a_next_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(out_tdata[2:0]) < SLOTS)
    else $error("next_slot beyond slot range");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !res_take ##1 out_tvalid)
    else $error("result overwritten while output stalled");
`endif

endmodule

[verif/testbench.sv]
// testbench for adc_round_robin_averager_unit: predicts each slot's scaled boxcar average
// and the next scan slot, checks every result transaction against it
// depends on arav_pkg and the adc_round_robin_averager_unit rtl
`timescale 1ns / 100ps

module testbench;
  import arav_pkg::*;

  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int READ_PCT     = 35;

  // config load styles
  localparam int CFG_RANDOM  = 0;
  localparam int CFG_LOWEST  = 1;
  localparam int CFG_HIGHEST = 2;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;  // sample[9:0], slot[12:10], zero pad
  logic                  in_tuser;  // mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata; // next_slot[2:0], scaled_value[18:3], pad
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  adc_round_robin_averager_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predicted state of the averager
  logic [SAMPLE_W-1:0]  avg_ring [DEPTH];
  int                   scan_slot;
  int                   scan_bucket;
  logic [CNT_REG_W-1:0] reg_slot_count;
  logic [SEL_W-1:0]     reg_scale_sel;
  logic [FACTOR_W-1:0]  reg_factor [NUM_FACTORS];

  res_t pending_results [$];
  int   err_count;
  bit   no_idle;
  bit   long_hold;

  function automatic void reset_averager_state();
    for (int i = 0; i < DEPTH; i++) avg_ring[i] = '0;
    scan_slot      = 0;
    scan_bucket    = 0;
    reg_slot_count = CNT_REG_W'(1);
    reg_scale_sel  = '0;
    for (int k = 0; k < NUM_FACTORS; k++) reg_factor[k] = FACTOR_RESET;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SLOT_COUNT: reg_slot_count = data[CNT_REG_W-1:0];
      REG_SCALE_SEL:  reg_scale_sel = data[SEL_W-1:0];
      default:        reg_factor[idx - REG_FACTOR0] = data[FACTOR_W-1:0];
    endcase
  endfunction

  function automatic res_t predict_average_step(input logic mode,
                                                input logic [SAMPLE_W-1:0] smp,
                                                input logic [SLOT_FIELD_W-1:0] sl);
    res_t                   r;
    logic [VALUE_W-1:0]     sum;
    logic [SEL_FIELD_W-1:0] sel;
    logic [PROD_W-1:0]      prod;
    int                     eff;
    r.scaled_value = '0;
    if (mode == MODE_TICK) begin
      if (scan_slot < SLOTS) avg_ring[scan_slot * AVG_SAMPLES + scan_bucket] = smp;
      if (reg_slot_count == 0) eff = 1;
      else if (int'(reg_slot_count) > SLOTS) eff = SLOTS;
      else eff = int'(reg_slot_count);
      scan_slot++;
      if (scan_slot >= eff) begin
        scan_slot   = 0;
        scan_bucket = (scan_bucket + 1) % AVG_SAMPLES;
      end
    end else begin
      sum = '0;
      if (int'(sl) < SLOTS) begin
        for (int b = 0; b < AVG_SAMPLES; b++) sum = sum + avg_ring[int'(sl) * AVG_SAMPLES + b];
      end
      sel = reg_scale_sel[int'(sl) * SEL_FIELD_W +: SEL_FIELD_W];
      if (int'(sel) >= NUM_FACTORS) sel = '0;
      prod = PROD_W'(sum) * PROD_W'(reg_factor[sel]);
      r.scaled_value = VALUE_W'(prod >> SCALE_SHIFT);
    end
    r.next_slot = SLOT_FIELD_W'(scan_slot);
    return r;
  endfunction

  task automatic send_item(input logic mode, input logic [SAMPLE_W-1:0] smp,
                           input logic [SLOT_FIELD_W-1:0] sl);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, sl, smp};
    in_tuser  <= mode;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pending_results.push_back(predict_average_step(mode, smp, sl));
  endtask

  // stop offering input, wait for every expected result, then let the pipe drain
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic load_config(input int style);
    logic [CFG_DATA_W-1:0] word;
    case (style)
      CFG_LOWEST:  word = CFG_DATA_W'(1);
      CFG_HIGHEST: word = CFG_DATA_W'(SLOTS);
      default:     word = CFG_DATA_W'($urandom);
    endcase
    write_register(REG_SLOT_COUNT, word);
    case (style)
      CFG_LOWEST:  word = '0;
      CFG_HIGHEST: word = '1;
      default:     word = CFG_DATA_W'($urandom);
    endcase
    write_register(REG_SCALE_SEL, word);
    for (int k = 0; k < NUM_FACTORS; k++) begin
      case (style)
        CFG_LOWEST:  word = '0;
        CFG_HIGHEST: word = CFG_DATA_W'(16'hFFFF);
        default:     word = CFG_DATA_W'($urandom);
      endcase
      write_register(REG_FACTOR0 + CFG_IDX_W'(k), word);
    end
  endtask

  task automatic run_traffic(input int count, input int read_pct);
    logic mode;
    for (int i = 0; i < count; i++) begin
      mode = ($urandom_range(0, 99) < read_pct) ? MODE_READ : MODE_TICK;
      send_item(mode, SAMPLE_W'($urandom_range(0, 1023)), SLOT_FIELD_W'($urandom_range(0, 7)));
    end
  endtask

  // empty store reads, then extreme samples on a one-slot scan
  task automatic test_after_reset();
    send_item(MODE_READ, '0, 3'd7);
    send_item(MODE_TICK, 10'd1023, '0);
    send_item(MODE_TICK, 10'd0, '1);
    send_item(MODE_READ, '1, 3'd0);
  endtask

  // one selector per slot, six and seven fall back to word zero
  task automatic test_scale_table();
    write_register(REG_SLOT_COUNT, CFG_DATA_W'(SLOTS));
    write_register(REG_SCALE_SEL, 24'hFAC688);
    write_register(REG_FACTOR0, CFG_DATA_W'(16'hFFFF));
    write_register(REG_FACTOR1, CFG_DATA_W'(0));
    write_register(REG_FACTOR2, CFG_DATA_W'(1));
    write_register(REG_FACTOR3, CFG_DATA_W'(16'h8000));
    write_register(REG_FACTOR4, CFG_DATA_W'(4096));
    write_register(REG_FACTOR5, CFG_DATA_W'(12345));
    for (int s = 0; s < SLOTS; s++) send_item(MODE_TICK, 10'd1023, SLOT_FIELD_W'(s));
    for (int s = 0; s < SLOTS; s++) send_item(MODE_READ, 10'd0, SLOT_FIELD_W'(s));
  endtask

  // count of zero, count above the slot range, count lowered below the scan position
  task automatic test_count_limits();
    write_register(REG_SLOT_COUNT, CFG_DATA_W'(0));
    send_item(MODE_TICK, 10'd512, '0);
    send_item(MODE_TICK, 10'd511, '0);
    write_register(REG_SLOT_COUNT, CFG_DATA_W'(15));
    while (scan_slot != 5) send_item(MODE_TICK, SAMPLE_W'($urandom_range(0, 1023)), '0);
    write_register(REG_SLOT_COUNT, CFG_DATA_W'(2));
    send_item(MODE_TICK, 10'd777, '0);
    send_item(MODE_READ, 10'd0, 3'd5);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 9; p++) begin
      if (p == 0) load_config(CFG_LOWEST);
      else if (p == 1) load_config(CFG_HIGHEST);
      else load_config(CFG_RANDOM);
      no_idle = (p == 2);
      run_traffic(110, READ_PCT);
    end
    no_idle = 1'b0;
  endtask

  // receiver stops for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    load_config(CFG_RANDOM);
    no_idle   = 1'b1;
    long_hold = 1'b1;
    run_traffic(40, 50);
    settle_block();
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int pause;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        pause     = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        pause = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (pause > 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.next_slot    = out_tdata[2:0];
      got.scaled_value = out_tdata[18:3];
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: next_slot %0d scaled_value %0d",
               got.next_slot, got.scaled_value);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.next_slot !== want.next_slot) begin
          $error("next_slot expected %0d actual %0d", want.next_slot, got.next_slot);
          err_count++;
        end
        if (got.scaled_value !== want.scaled_value) begin
          $error("scaled_value expected %0d actual %0d", want.scaled_value, got.scaled_value);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
          || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    err_count  = 0;
    no_idle    = 1'b0;
    long_hold  = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SLOT_COUNT;
    cfg_data  <= '0;
    reset_averager_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_scale_table();
    test_count_limits();
    test_random_phases();
    test_backpressure();
    settle_block();
    if (err_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
rtl/core/arav_pkg.sv
rtl/core/arav_ram.sv
rtl/core/arav_core.sv
rtl/core/adc_round_robin_averager_unit.sv
verif/testbench.sv
